@@ rtl/iqrm_pkg.sv @@
`default_nettype none
package iqrm_pkg;

   // Payload widths of the two channels
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned MEAN_W   = 16;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned STATUS_W = 2;

   // Default sizing of the sample store
   localparam int unsigned MAX_SAMPLES_DEF = 64;
   localparam int unsigned SAMPLE_BITS_DEF = 16;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_NONE  = 2'd2,
      ST_OVER  = 2'd3
   } status_type;

endpackage
`default_nettype wire

@@ rtl/iqrm_if.sv @@
`default_nettype none
// Request channel: one distance sample per transfer
interface iqrm_req_if;
   logic                          valid;
   logic                          ready;
   logic [iqrm_pkg::SAMPLE_W-1:0] sample;
   logic                          last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

// Response channel: one result per burst
interface iqrm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [iqrm_pkg::MEAN_W-1:0]   mean;
   logic [iqrm_pkg::COUNT_W-1:0]  inlier_count;
   logic [iqrm_pkg::STATUS_W-1:0] status;

   modport source (output valid, output mean, output inlier_count, output status,
                   input ready);
   modport sink   (input valid, input mean, input inlier_count, input status,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/iqrm_divider.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle
module iqrm_divider #(
   parameter int unsigned DIVIDEND_W = 22,
   parameter int unsigned DIVISOR_W  = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    rem_sub;
   logic                  ge;

   // Shift in the next dividend bit and try to subtract
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge      = (rem_sh >= {1'b0, divisor});
      rem_sub = rem_sh - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ rtl/iqr_outlier_rejecting_mean_unit.sv @@
`default_nettype none
// Interquartile-range outlier-rejecting mean. Samples stream in one per cycle
// into a store of MAX_SAMPLES entries (held twice, in two synchronous RAMs)
// until one arrives with last set; samples beyond capacity are dropped and
// flagged. The burst is then evaluated while the request side is held off:
// a rank pass finds Q1 and Q3 by counting, for every stored sample, the
// samples below it; a second sweep sums the samples strictly inside
// Q1-1.5*IQR .. Q3+1.5*IQR; a bit-serial divider then gives the truncated
// mean. One response follows per burst; the next burst may load while it
// waits.
module iqr_outlier_rejecting_mean_unit #(
   parameter int unsigned MAX_SAMPLES = iqrm_pkg::MAX_SAMPLES_DEF,
   parameter int unsigned SAMPLE_BITS = iqrm_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   iqrm_req_if.sink   req_chan,
   iqrm_rsp_if.source rsp_chan
);

   localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned AW = $clog2(MAX_SAMPLES);
   localparam int unsigned SW = SAMPLE_BITS + CW;
   localparam int unsigned LW = SAMPLE_BITS + 4;
   localparam int unsigned MW = iqrm_pkg::MEAN_W;
   localparam int unsigned OW = iqrm_pkg::COUNT_W;
   localparam int unsigned IW = iqrm_pkg::SAMPLE_W;

   typedef enum logic [2:0] {
      S_LOAD, S_RANK, S_LIMITS, S_SUM, S_DIV, S_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [CW-1:0]          n_ff, n_in;
   logic [CW-1:0]          i_ff, i_in;
   logic [CW-1:0]          j_ff, j_in;
   logic [CW-1:0]          jd_ff, jd_in;
   logic                   pv_ff, pv_in;
   logic [CW-1:0]          rank_ff, rank_in;
   logic [SAMPLE_BITS-1:0] q1_ff, q1_in;
   logic [SAMPLE_BITS-1:0] q3_ff, q3_in;
   logic signed [LW-1:0]   lo2_ff, lo2_in;
   logic signed [LW-1:0]   hi2_ff, hi2_in;
   logic [SW-1:0]          sum_ff, sum_in;
   logic [CW-1:0]          inl_ff, inl_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0]          mean_ff, mean_in;
   logic [OW-1:0]          icnt_ff, icnt_in;
   iqrm_pkg::status_type   status_ff, status_in;

   logic [SAMPLE_BITS-1:0] mem_a [MAX_SAMPLES];
   logic [SAMPLE_BITS-1:0] mem_b [MAX_SAMPLES];
   logic [SAMPLE_BITS-1:0] a_q_ff;
   logic [SAMPLE_BITS-1:0] b_q_ff;

   logic                   req_fire;
   logic                   store_en;
   logic [SAMPLE_BITS-1:0] sample_in;
   logic [SAMPLE_BITS+IW-1:0] sample_ext;
   logic [CW+1:0]          n3;
   logic [CW-1:0]          q1_idx, q3_idx;
   logic                   less;
   logic [SAMPLE_BITS-1:0] iqr;
   logic signed [LW-1:0]   x2;
   logic                   div_start;
   logic                   div_done;
   logic [SW-1:0]          quo;
   logic [SW+MW-1:0]       quo_ext;
   logic [CW+OW-1:0]       inl_ext;

   assign req_fire   = req_chan.valid && (state_ff == S_LOAD);
   assign store_en   = req_fire && (count_ff < CW'(MAX_SAMPLES));
   assign sample_ext = {{SAMPLE_BITS{1'b0}}, req_chan.sample};
   assign sample_in  = sample_ext[SAMPLE_BITS-1:0];

   // Store each sample twice, read both copies every cycle
   always_ff @(posedge clock) begin
      if (store_en) begin
         mem_a[count_ff[AW-1:0]] <= sample_in;
         mem_b[count_ff[AW-1:0]] <= sample_in;
      end
      a_q_ff <= mem_a[i_ff[AW-1:0]];
      b_q_ff <= mem_b[j_ff[AW-1:0]];
   end

   // Quartile ranks n/4 and 3n/4
   assign n3     = {2'b00, n_ff} + {1'b0, n_ff, 1'b0};
   assign q3_idx = n3[CW+1:2];
   assign q1_idx = {2'b00, n_ff[CW-1:2]};

   // Ties rank by store position, so every rank is taken once
   assign less = (b_q_ff < a_q_ff) || ((b_q_ff == a_q_ff) && (jd_ff < i_ff));
   assign iqr  = q3_ff - q1_ff;
   assign x2   = signed'({3'b000, a_q_ff, 1'b0});

   assign quo_ext = {{MW{1'b0}}, quo};
   assign inl_ext = {{OW{1'b0}}, inl_ff};

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      jd_in        = jd_ff;
      pv_in        = 1'b0;
      rank_in      = rank_ff;
      q1_in        = q1_ff;
      q3_in        = q3_ff;
      lo2_in       = lo2_ff;
      hi2_in       = hi2_ff;
      sum_in       = sum_ff;
      inl_in       = inl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mean_in      = mean_ff;
      icnt_in      = icnt_ff;
      status_in    = status_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (store_en) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last) begin
                  n_in     = store_en ? count_ff + 1'b1 : count_ff;
                  count_in = '0;
                  i_in     = '0;
                  j_in     = '0;
                  rank_in  = '0;
                  inl_in   = '0;
                  state_in = (n_in == '0) ? S_OUT : S_RANK;
               end
            end
         end
         S_RANK: begin
            // issue the next compare read
            if (j_ff < n_ff) begin
               j_in  = j_ff + 1'b1;
               jd_in = j_ff;
               pv_in = 1'b1;
            end
            if (pv_ff) begin
               rank_in = rank_ff + CW'(less);
            end
            // rank of sample i is complete
            if ((j_ff == n_ff) && !pv_ff) begin
               if (rank_ff == q1_idx) begin
                  q1_in = a_q_ff;
               end
               if (rank_ff == q3_idx) begin
                  q3_in = a_q_ff;
               end
               i_in    = i_ff + 1'b1;
               j_in    = '0;
               rank_in = '0;
               if (i_in == n_ff) begin
                  state_in = S_LIMITS;
               end
            end
         end
         S_LIMITS: begin
            // doubled limits: 2*Q1-3*IQR and 2*Q3+3*IQR
            lo2_in = signed'({3'b000, q1_ff, 1'b0}) - signed'({3'b000, iqr, 1'b0})
                     - signed'({4'b0000, iqr});
            hi2_in = signed'({3'b000, q3_ff, 1'b0}) + signed'({3'b000, iqr, 1'b0})
                     + signed'({4'b0000, iqr});
            i_in     = '0;
            sum_in   = '0;
            inl_in   = '0;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (i_ff < n_ff) begin
               i_in  = i_ff + 1'b1;
               pv_in = 1'b1;
            end
            if (pv_ff && (x2 > lo2_ff) && (x2 < hi2_ff)) begin
               sum_in = sum_ff + SW'(a_q_ff);
               inl_in = inl_ff + 1'b1;
            end
            if ((i_ff == n_ff) && !pv_ff) begin
               if (inl_ff == '0) begin
                  state_in = S_OUT;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               priority if (n_ff == '0) begin
                  status_in = iqrm_pkg::ST_EMPTY;
                  mean_in   = '0;
                  icnt_in   = '0;
               end else if (inl_ff == '0) begin
                  status_in = iqrm_pkg::ST_NONE;
                  mean_in   = '0;
                  icnt_in   = '0;
               end else begin
                  status_in = ovf_ff ? iqrm_pkg::ST_OVER : iqrm_pkg::ST_OK;
                  mean_in   = quo_ext[MW-1:0];
                  icnt_in   = inl_ext[OW-1:0];
               end
               ovf_in   = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   // Hold state and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff      <= n_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      jd_ff     <= jd_in;
      rank_ff   <= rank_in;
      q1_ff     <= q1_in;
      q3_ff     <= q3_in;
      lo2_ff    <= lo2_in;
      hi2_ff    <= hi2_in;
      sum_ff    <= sum_in;
      inl_ff    <= inl_in;
      mean_ff   <= mean_in;
      icnt_ff   <= icnt_in;
      status_ff <= status_in;
   end

   iqrm_divider #(
      .DIVIDEND_W (SW),
      .DIVISOR_W  (CW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (inl_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign req_chan.ready        = (state_ff == S_LOAD);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.mean         = mean_ff;
   assign rsp_chan.inlier_count = icnt_ff;
   assign rsp_chan.status       = status_ff;

endmodule
`default_nettype wire

@@ tb/tb_iqr_outlier_rejecting_mean_unit.sv @@
module tb_iqr_outlier_rejecting_mean_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SAMPLE_W = iqrm_pkg::SAMPLE_W;
   localparam int unsigned MEAN_W   = iqrm_pkg::MEAN_W;
   localparam int unsigned COUNT_W  = iqrm_pkg::COUNT_W;
   localparam int unsigned DEPTH = iqrm_pkg::MAX_SAMPLES_DEF;
   localparam longint CYCLE_LIMIT = 64'd12_000_000;

   typedef struct packed {
      logic [MEAN_W-1:0]    mean;
      logic [COUNT_W-1:0]   inlier_count;
      iqrm_pkg::status_type status;
   } burst_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   iqrm_req_if req_chan ();
   iqrm_rsp_if rsp_chan ();

   iqr_outlier_rejecting_mean_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   // Predictor state
   logic [SAMPLE_W-1:0] burst_store [DEPTH];
   int unsigned         burst_fill;
   bit                  burst_dropped;
   burst_result_type    pending_results [$];

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_off;
   int  errors;
   longint cycle_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Work out the result of a closed burst: sort, quartiles, strict limits
   function automatic burst_result_type evaluate_burst();
      burst_result_type    r;
      logic [SAMPLE_W-1:0] ranked [$];
      longint              q1, q3, iqr, lo2, hi2, x2;
      longint unsigned     total;
      int unsigned         hits;
      total = 0;
      hits  = 0;
      r     = '0;
      r.status = iqrm_pkg::ST_EMPTY;
      if (burst_fill == 0) return r;
      for (int i = 0; i < burst_fill; i++) ranked = {ranked, burst_store[i]};
      ranked.sort();
      q1  = ranked[burst_fill / 4];
      q3  = ranked[(burst_fill * 3) / 4];
      iqr = q3 - q1;
      lo2 = 2 * q1 - 3 * iqr;
      hi2 = 2 * q3 + 3 * iqr;
      foreach (ranked[i]) begin
         x2 = 2 * longint'(ranked[i]);
         if (x2 > lo2 && x2 < hi2) begin
            total += ranked[i];
            hits++;
         end
      end
      if (hits == 0) begin
         r.status = iqrm_pkg::ST_NONE;
      end else begin
         r.mean         = MEAN_W'(total / hits);
         r.inlier_count = COUNT_W'(hits);
         r.status       = burst_dropped ? iqrm_pkg::ST_OVER : iqrm_pkg::ST_OK;
      end
      return r;
   endfunction

   // Track accepted requests and queue expectations
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         if (burst_fill < DEPTH) begin
            burst_store[burst_fill] = req_chan.sample;
            burst_fill++;
         end else begin
            burst_dropped = 1'b1;
         end
         if (req_chan.last) begin
            pending_results = {pending_results, evaluate_burst()};
            burst_fill    = 0;
            burst_dropped = 1'b0;
         end
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      burst_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result mean=%0d count=%0d status=%0d",
                   rsp_chan.mean, rsp_chan.inlier_count, rsp_chan.status);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.mean !== want.mean) begin
               $error("mean: expected %0d, got %0d", want.mean, rsp_chan.mean);
               errors++;
            end
            if (rsp_chan.inlier_count !== want.inlier_count) begin
               $error("inlier_count: expected %0d, got %0d",
                      want.inlier_count, rsp_chan.inlier_count);
               errors++;
            end
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               errors++;
            end
         end
      end
   end

   // Drive the result ready, with random stalls and an optional long hold-off
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_iqr_outlier_rejecting_mean_unit: FAIL");
         $finish;
      end
   end

   // Offer one request and hold it until accepted; valid stays up for the next one
   task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= value;
      req_chan.last   <= is_last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_burst(input logic [SAMPLE_W-1:0] values [$]);
      foreach (values[i]) send_sample(values[i], i == values.size() - 1);
   endtask

   // Random burst: mostly clustered values with a few outliers, sizes mostly small
   task automatic send_random_burst(output int unsigned sent);
      logic [SAMPLE_W-1:0] vals [$];
      int unsigned n, centre, spread, pick;
      pick = $urandom_range(99);
      n = (pick < 8) ? $urandom_range(DEPTH + 6, DEPTH - 2) : $urandom_range(16, 1);
      centre = $urandom_range(65535);
      spread = 1 << $urandom_range(12);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0:       vals = {vals, SAMPLE_W'($urandom)};
            1:       vals = {vals, ($urandom_range(1) ? 16'hFFFF : 16'h0000)};
            default: vals = {vals, SAMPLE_W'(centre + $urandom_range(spread) - spread / 2)};
         endcase
      end
      send_burst(vals);
      sent = n;
   endtask

   // Drop valid, then wait for every expected result to come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_extremes();
      send_burst({16'h0000});
      send_burst({16'hFFFF});
      send_burst({16'h0000, 16'hFFFF});
      send_burst({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
      send_burst({16'd100, 16'd100, 16'd100, 16'd100});
      send_burst({16'd10, 16'd20, 16'd30, 16'd40, 16'd5000});
      send_burst({16'hAAAA, 16'h5555, 16'h1234, 16'hFEDC});
      drain();
   endtask

   task automatic test_overflow();
      logic [SAMPLE_W-1:0] vals [$];
      // exactly full, then past full with two dropped samples, the last one among them
      for (int i = 0; i < DEPTH; i++) vals = {vals, SAMPLE_W'(1000 + i)};
      send_burst(vals);
      vals = {vals, 16'hFFFF, 16'h0000};
      send_burst(vals);
      drain();
   endtask

   task automatic test_random(input int unsigned target);
      int unsigned sent, got;
      got = 0;
      while (got < target) begin
         send_random_burst(sent);
         got += sent;
      end
      drain();
   endtask

   // Stall the receiver for a long stretch while requests keep coming
   task automatic test_backpressure();
      int unsigned sent;
      fork
         begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (6) send_random_burst(sent);
      join
      drain();
   endtask

   initial begin
      errors          = 0;
      cycle_count     = 0;
      burst_fill      = 0;
      burst_dropped   = 1'b0;
      hold_off        = 1'b0;
      send_idle_pct   = 24;
      recv_idle_pct   = 67;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      req_chan.last   = 1'b0;
      rsp_chan.ready  = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_overflow();
      test_random(370);
      send_idle_pct = 67;
      recv_idle_pct = 24;
      test_random(370);
      test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(370);

      repeat (200) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("tb_iqr_outlier_rejecting_mean_unit: PASS");
      end else begin
         $display("tb_iqr_outlier_rejecting_mean_unit: FAIL");
      end
      $finish;
   end

endmodule
